// File: sv/segment_allocation_check_table_unit_defines.svh
// ----------------------------------------------------------------------------
// segment allocation check table - assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ALLOCATION_CHECK_TABLE_UNIT_DEFINES_SVH
`define SEGMENT_ALLOCATION_CHECK_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define SACT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sact assertion failed");

// next-cycle implication
`define SACT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sact assertion failed");

`endif

// File: sv/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg
// command and reason codes and the table entry layout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sact_pkg;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_ACCESS = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [2:0] RSN_OK      = 3'd0;
	localparam logic [2:0] RSN_OVERLAP = 3'd1;
	localparam logic [2:0] RSN_LIMIT   = 3'd2;
	localparam logic [2:0] RSN_FULL    = 3'd3;
	localparam logic [2:0] RSN_NOENTRY = 3'd4;
	localparam logic [2:0] RSN_BEYOND  = 3'd5;

	localparam logic [15:0] MEM_LIMIT_RESET = 16'd1024;

	// one table entry as stored in the entry ram
	typedef struct packed {
		logic [7:0] proc_num;
		logic [9:0] seg_id;
		logic [9:0] seg_base;
		logic [9:0] seg_size;
	} entry_t;

endpackage

// File: sv/sact_ram.sv
// ----------------------------------------------------------------------------
// sact_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sact_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/segment_allocation_check_table_unit.sv
// ----------------------------------------------------------------------------
// segment_allocation_check_table_unit
// memory-protection table: allocate, access check and clear of segments
// ----------------------------------------------------------------------------
// Each request word (cmd, proc_num, seg_id, seg_base, seg_offset) returns one
// result word (fault, reason). Allocate and access walk the whole table:
// a single compare unit steps through the entry ram one entry per cycle,
// then a drain step compares the last ram read, a finish step decides and
// writes back once the output register is free, and the block returns to
// idle to take the next word. Clear and the unused command skip the walk
// and go straight to the finish step. in_ready is low while a request
// is in work; a finished result waits in the output register, so a new
// request can be taken while the previous result is still unclaimed. The
// mem_limit register (reset 1024) is written through the cfg port, which is
// always ready and must only be used while the block is idle.
`timescale 1ns / 1ps
`include "segment_allocation_check_table_unit_defines.svh"

module segment_allocation_check_table_unit
	import sact_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  proc_num,
	input  logic [9:0]  seg_id,
	input  logic [9:0]  seg_base,
	input  logic [9:0]  seg_offset,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        fault,
	output logic [2:0]  reason,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// latched request word
	logic [1:0] cmd_q;
	logic [7:0] proc_q;
	logic [9:0] id_q;
	logic [9:0] base_q;
	logic [9:0] off_q;

	logic [15:0] mem_limit_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	// scan address and the compare stage one behind it
	logic [IDX_W-1:0] scan_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// sticky scan results
	logic             ovl_q;
	logic             hit_q;
	logic             fits_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_q;

	// output register
	logic       out_valid_q;
	logic       fault_q;
	logic [2:0] reason_q;

	// ram side
	entry_t rd_entry;
	entry_t wr_entry;
	logic   ram_we;
	logic   ram_re;

	// shared compare unit
	logic ent_v;
	logic base_eq;
	logic pid_eq;
	logic ovl_now;
	logic hit_now;
	logic fits_now;

	// decision
	logic       fin_go;
	logic       res_fault;
	logic [2:0] res_reason;
	logic       do_write;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign fault     = fault_q;
	assign reason    = reason_q;

	// one entry against the latched request
	always_comb begin
		ent_v    = valid_q[cmp_idx_s1];
		base_eq  = (rd_entry.seg_base == base_q);
		pid_eq   = (rd_entry.proc_num == proc_q) && (rd_entry.seg_id == id_q);
		ovl_now  = ent_v && (base_eq || pid_eq);
		hit_now  = ent_v && base_eq && pid_eq;
		fits_now = (off_q <= rd_entry.seg_size);
	end

	// final verdict once the whole table has been looked at
	always_comb begin
		res_fault  = 1'b0;
		res_reason = RSN_OK;
		do_write   = 1'b0;
		case (cmd_q)
			CMD_ALLOC: begin
				if (ovl_q) begin
					res_fault  = 1'b1;
					res_reason = RSN_OVERLAP;
				end else if (16'(base_q) > mem_limit_q) begin
					res_fault  = 1'b1;
					res_reason = RSN_LIMIT;
				end else if (!free_found_q) begin
					res_fault  = 1'b1;
					res_reason = RSN_FULL;
				end else begin
					do_write = 1'b1;
				end
			end
			CMD_ACCESS: begin
				if (!hit_q) begin
					res_fault  = 1'b1;
					res_reason = RSN_NOENTRY;
				end else if (!fits_q) begin
					res_fault  = 1'b1;
					res_reason = RSN_BEYOND;
				end
			end
			default: begin
				res_fault  = 1'b0;
				res_reason = RSN_OK;
			end
		endcase
	end

	// finish only when the output register is free or being emptied
	assign fin_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign ram_we = fin_go && do_write;
	assign ram_re = (state_q == ST_SCAN);

	always_comb begin
		wr_entry.proc_num = proc_q;
		wr_entry.seg_id   = id_q;
		wr_entry.seg_base = base_q;
		wr_entry.seg_size = off_q;
	end

	sact_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_q),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (scan_q),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mem_limit_q  <= MEM_LIMIT_RESET;
			valid_q      <= '0;
			scan_q       <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			ovl_q        <= 1'b0;
			hit_q        <= 1'b0;
			fits_q       <= 1'b0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			out_valid_q  <= 1'b0;
			fault_q      <= 1'b0;
			reason_q     <= RSN_OK;
			cmd_q        <= CMD_ALLOC;
			proc_q       <= '0;
			id_q         <= '0;
			base_q       <= '0;
			off_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mem_limit_q <= cfg_data;
			end

			// result handed over, unless the next one is loaded at this edge
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end

			// collect compare results of the entry read last cycle
			if (cmp_vld_s1) begin
				if (ovl_now) begin
					ovl_q <= 1'b1;
				end
				if (hit_now && !hit_q) begin
					hit_q  <= 1'b1;
					fits_q <= fits_now;
				end
				if (!ent_v && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= cmp_idx_s1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q        <= cmd;
						proc_q       <= proc_num;
						id_q         <= seg_id;
						base_q       <= seg_base;
						off_q        <= seg_offset;
						scan_q       <= '0;
						cmp_vld_s1   <= 1'b0;
						ovl_q        <= 1'b0;
						hit_q        <= 1'b0;
						fits_q       <= 1'b0;
						free_found_q <= 1'b0;
						// clear and unused codes need no table walk
						if (cmd == CMD_ALLOC || cmd == CMD_ACCESS) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= 1'b1;
					cmp_idx_s1 <= scan_q;
					if (scan_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last entry is compared in this cycle
					cmp_vld_s1 <= 1'b0;
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						fault_q     <= res_fault;
						reason_q    <= res_reason;
						if (cmd_q == CMD_CLEAR) begin
							valid_q <= '0;
						end else if (do_write) begin
							valid_q[free_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a new entry never lands on a live slot
	`SACT_ASSERT_IMP(a_no_overwrite, clk, arst_n, ram_we, !valid_q[free_q])
	// fault and reason code agree
	`SACT_ASSERT_IMP(a_fault_reason, clk, arst_n, out_valid_q,
		fault_q == (reason_q != RSN_OK))
	// busy after taking a request
	`SACT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// clear empties the whole table
	`SACT_ASSERT_NXT(a_clear_empties, clk, arst_n, fin_go && cmd_q == CMD_CLEAR,
		valid_q == '0)

endmodule
